### rtl/tspi_pkg.sv
// Shared types and constants of the timestamped position interpolator.
// Holds the controller/datapath command and status structs and field widths.
// Depends on nothing; every other file of the block imports it.
`default_nettype none

package tspi_pkg;

	localparam int NOW_W     = 40;
	localparam int TIME_W    = 42;
	localparam int POS_W     = 24;
	localparam int DLY_W     = 16;
	localparam int OP_W      = 2;
	localparam int DIFF_W    = POS_W + 1;
	localparam int NUM_W     = TIME_W + 1;
	localparam int AN_LO_W   = 21;
	localparam int PROD_W    = DIFF_W + TIME_W;
	localparam int Q_W       = 27;
	localparam int LERP_W    = 30;
	localparam int DCNT_W    = 7;
	localparam int S_DATA_W  = 96;
	localparam int M_DATA_W  = 56;

	localparam logic [OP_W-1:0] OP_ACTIVATE = 2'd0;
	localparam logic [OP_W-1:0] OP_SAMPLE   = 2'd1;
	localparam logic [OP_W-1:0] OP_QUERY    = 2'd2;

	typedef struct packed {
		logic capture;
		logic fill_wr;
		logic samp_prev_wr;
		logic samp_cur_wr;
		logic rd_n;
		logic ld_n;
		logic rd_p;
		logic step_back;
		logic ld_p;
		logic lerp_setup;
		logic copy_n;
		logic mul_lo;
		logic mul_hi;
		logic div_step;
		logic lerp_done;
		logic out_load;
	} tspi_cmd_t;

	typedef struct packed {
		logic was_vis;
		logic render_le_n;
		logic walk_stop;
		logic span_pos;
		logic fill_last;
		logic div_last;
	} tspi_status_t;

endpackage

`default_nettype wire

### rtl/tspi_ctrl.sv
// Controller state machine of the timestamped position interpolator.
// Sequences fill, sample writes, the backward walk, multiply and divide.
// Depends on tspi_pkg; drives the datapath only through tspi_cmd_t.
`default_nettype none

module tspi_ctrl (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       s_tvalid,
	output logic                            s_tready,
	input  wire logic [tspi_pkg::OP_W-1:0]  s_tuser,
	output logic                            m_tvalid,
	input  wire logic                       m_tready,
	input  wire tspi_pkg::tspi_status_t     status,
	output tspi_pkg::tspi_cmd_t             cmd
);
	import tspi_pkg::*;

	typedef enum logic [3:0] {
		ST_IDLE, ST_FILL, ST_SAMP_PREV, ST_SAMP_CUR, ST_RD_N, ST_CHK_N,
		ST_RD_P, ST_CHK_P, ST_SETUP, ST_MUL_LO, ST_MUL_HI, ST_DIV, ST_FIN, ST_OUT
	} state_t;

	state_t state_q;
	logic   out_free;

	assign s_tready = (state_q == ST_IDLE);
	assign out_free = !m_tvalid || m_tready;

	always_comb begin
		cmd = '0;
		unique case (state_q)
			ST_IDLE:      cmd.capture = s_tvalid;
			ST_FILL:      cmd.fill_wr = 1'b1;
			ST_SAMP_PREV: cmd.samp_prev_wr = 1'b1;
			ST_SAMP_CUR:  cmd.samp_cur_wr = 1'b1;
			ST_RD_N:      cmd.rd_n = 1'b1;
			ST_CHK_N:     cmd.ld_n = 1'b1;
			ST_RD_P:      cmd.rd_p = 1'b1;
			ST_CHK_P: begin
				cmd.ld_p = status.walk_stop;
				cmd.step_back = !status.walk_stop;
			end
			ST_SETUP: begin
				cmd.lerp_setup = status.span_pos;
				cmd.copy_n = !status.span_pos;
			end
			ST_MUL_LO:    cmd.mul_lo = 1'b1;
			ST_MUL_HI:    cmd.mul_hi = 1'b1;
			ST_DIV:       cmd.div_step = 1'b1;
			ST_FIN:       cmd.lerp_done = 1'b1;
			ST_OUT:       cmd.out_load = out_free;
			default:      cmd = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			m_tvalid <= 1'b0;
		end else begin
			if (cmd.out_load) begin
				m_tvalid <= 1'b1;
			end else if (m_tready) begin
				m_tvalid <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						unique case (s_tuser)
							OP_ACTIVATE: state_q <= ST_FILL;
							OP_SAMPLE:   state_q <= status.was_vis ? ST_SAMP_CUR : ST_SAMP_PREV;
							OP_QUERY:    state_q <= ST_RD_N;
							default:     state_q <= ST_IDLE;
						endcase
					end
				end
				ST_FILL:      if (status.fill_last) state_q <= ST_IDLE;
				ST_SAMP_PREV: state_q <= ST_SAMP_CUR;
				ST_SAMP_CUR:  state_q <= ST_IDLE;
				ST_RD_N:      state_q <= ST_CHK_N;
				ST_CHK_N:     state_q <= status.render_le_n ? ST_RD_P : ST_OUT;
				ST_RD_P:      state_q <= ST_CHK_P;
				ST_CHK_P:     state_q <= status.walk_stop ? ST_SETUP : ST_RD_P;
				ST_SETUP:     state_q <= status.span_pos ? ST_MUL_LO : ST_OUT;
				ST_MUL_LO:    state_q <= ST_MUL_HI;
				ST_MUL_HI:    state_q <= ST_DIV;
				ST_DIV:       if (status.div_last) state_q <= ST_FIN;
				ST_FIN:       state_q <= ST_OUT;
				ST_OUT:       if (out_free) state_q <= ST_IDLE;
				default:      state_q <= ST_IDLE;
			endcase
		end
	end

	// A new result must never overwrite one that is still waiting.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (!m_tvalid || m_tready))
		else $error("result register overwritten");

	// After an accepted item with a defined operation the block is busy in the following cycle.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready && (s_tuser == OP_ACTIVATE || s_tuser == OP_SAMPLE ||
			s_tuser == OP_QUERY)) |=> !s_tready)
		else $error("accepted an item while busy");

	// The multiplier, and so the divider, only runs after the span was found positive.
	a_div_after_setup: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.mul_lo |-> $past(cmd.lerp_setup))
		else $error("multiply started without setup");

endmodule

`default_nettype wire

### rtl/tspi_dp.sv
// Datapath of the timestamped position interpolator: sample ring memory,
// walk pointers, split multiplier, restoring divider and saturation.
// Depends on tspi_pkg; controlled by tspi_ctrl through tspi_cmd_t.
`default_nettype none

module tspi_dp #(
	parameter int DEPTH = 8
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           cfg_wr_en,
	input  wire logic [tspi_pkg::DLY_W-1:0]     cfg_wr_data,
	input  wire logic [tspi_pkg::S_DATA_W-1:0]  s_tdata,
	output logic      [tspi_pkg::M_DATA_W-1:0]  m_tdata,
	input  wire tspi_pkg::tspi_cmd_t            cmd,
	output tspi_pkg::tspi_status_t              status
);
	import tspi_pkg::*;

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam logic [AW-1:0] LAST_SLOT = AW'(DEPTH - 1);

	function automatic logic [AW-1:0] slot_before(input logic [AW-1:0] s);
		return (s == '0) ? LAST_SLOT : s - AW'(1);
	endfunction

	// Sample ring.
	logic [TIME_W-1:0] time_mem [DEPTH];
	logic [POS_W-1:0]  x_mem    [DEPTH];
	logic [POS_W-1:0]  y_mem    [DEPTH];

	logic [DLY_W-1:0]  delay_q;
	logic [NOW_W-1:0]  now_q;
	logic [TIME_W-1:0] render_q;
	logic [POS_W-1:0]  px_q, py_q;
	logic              vis_q, was_vis_q, upd_q;
	logic [AW-1:0]     ws_q, nx_q, fill_cnt_q;
	logic [POS_W-1:0]  shown_x_q, shown_y_q;

	logic [TIME_W-1:0] rd_time_q;
	logic [POS_W-1:0]  rd_x_q, rd_y_q;
	logic [TIME_W-1:0] tn_q, tp_q;
	logic [POS_W-1:0]  xn_q, yn_q, xp_q, yp_q;

	logic [TIME_W-1:0] span_q, an_q;
	logic [DIFF_W-1:0] adx_q, ady_q;
	logic              negx_q, negy_q;
	logic [PROD_W-1:0] prodx_q, prody_q;
	logic [TIME_W-1:0] remx_q, remy_q;
	logic [Q_W-1:0]    qx_q, qy_q;
	logic              ovfx_q, ovfy_q;
	logic [DCNT_W-1:0] dcnt_q;

	logic              wr_en;
	logic [AW-1:0]     wr_addr, rd_addr;
	logic [TIME_W-1:0] wr_time;
	logic              rd_en;
	logic [NUM_W-1:0]  span_d, num_d;
	logic [DIFF_W-1:0] dx_d, dy_d;
	logic [NUM_W-1:0]  trialx, trialy;
	logic              gex, gey;

	always_comb begin
		wr_en = cmd.fill_wr || cmd.samp_prev_wr || cmd.samp_cur_wr;
		if (cmd.fill_wr) begin
			wr_addr = fill_cnt_q;
			wr_time = {2'b00, now_q} - TIME_W'(DEPTH) + TIME_W'(fill_cnt_q);
		end else if (cmd.samp_prev_wr) begin
			wr_addr = slot_before(ws_q);
			wr_time = render_q;
		end else begin
			wr_addr = ws_q;
			wr_time = was_vis_q ? {2'b00, now_q} : render_q;
		end
		rd_en = cmd.rd_n || cmd.rd_p;
		rd_addr = cmd.rd_n ? slot_before(ws_q) : slot_before(nx_q);
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			time_mem[wr_addr] <= wr_time;
			x_mem[wr_addr] <= px_q;
			y_mem[wr_addr] <= py_q;
		end
		if (rd_en) begin
			rd_time_q <= time_mem[rd_addr];
			rd_x_q <= x_mem[rd_addr];
			rd_y_q <= y_mem[rd_addr];
		end
	end

	// Signed widening subtractions for the interpolation setup, and the divider's trial compares.
	always_comb begin
		span_d = {tn_q[TIME_W-1], tn_q} - {tp_q[TIME_W-1], tp_q};
		num_d = {render_q[TIME_W-1], render_q} - {tp_q[TIME_W-1], tp_q};
		dx_d = {xn_q[POS_W-1], xn_q} - {xp_q[POS_W-1], xp_q};
		dy_d = {yn_q[POS_W-1], yn_q} - {yp_q[POS_W-1], yp_q};
		trialx = {remx_q, prodx_q[PROD_W-1]};
		trialy = {remy_q, prody_q[PROD_W-1]};
		gex = trialx >= {1'b0, span_q};
		gey = trialy >= {1'b0, span_q};
	end

	always_comb begin
		status.was_vis = was_vis_q;
		status.render_le_n = $signed(render_q) <= $signed(rd_time_q);
		status.walk_stop = (slot_before(nx_q) == ws_q) ||
			($signed(rd_time_q) <= $signed(render_q));
		status.span_pos = !span_d[NUM_W-1] && (span_d != '0);
		status.fill_last = (fill_cnt_q == LAST_SLOT);
		status.div_last = (dcnt_q == DCNT_W'(PROD_W - 1));
	end

	function automatic logic [POS_W-1:0] lerp_sat(input logic [POS_W-1:0] p,
		input logic [Q_W-1:0] q, input logic ovf, input logic neg);
		logic [Q_W-1:0]    mag;
		logic [LERP_W-1:0] r;
		mag = ovf ? {Q_W{1'b1}} : q;
		r = neg ? (LERP_W'($signed(p)) - LERP_W'(mag)) : (LERP_W'($signed(p)) + LERP_W'(mag));
		if (!r[LERP_W-1] && (r[LERP_W-2:POS_W-1] != '0)) begin
			return {1'b0, {(POS_W-1){1'b1}}};
		end else if (r[LERP_W-1] && (r[LERP_W-2:POS_W-1] != '1)) begin
			return {1'b1, {(POS_W-1){1'b0}}};
		end
		return r[POS_W-1:0];
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			delay_q <= '0;
			ws_q <= '0;
			was_vis_q <= 1'b1;
			shown_x_q <= '0;
			shown_y_q <= '0;
			fill_cnt_q <= '0;
			dcnt_q <= '0;
		end else begin
			if (cfg_wr_en) begin
				delay_q <= cfg_wr_data;
			end
			if (cmd.capture) begin
				fill_cnt_q <= '0;
			end else if (cmd.fill_wr) begin
				fill_cnt_q <= fill_cnt_q + AW'(1);
			end
			if (cmd.samp_cur_wr) begin
				was_vis_q <= vis_q;
				ws_q <= (ws_q == LAST_SLOT) ? '0 : ws_q + AW'(1);
			end
			if (cmd.mul_hi) begin
				dcnt_q <= '0;
			end else if (cmd.div_step) begin
				dcnt_q <= dcnt_q + DCNT_W'(1);
			end
			if (cmd.copy_n) begin
				shown_x_q <= xn_q;
				shown_y_q <= yn_q;
			end else if (cmd.lerp_done) begin
				shown_x_q <= lerp_sat(xp_q, qx_q, ovfx_q, negx_q);
				shown_y_q <= lerp_sat(yp_q, qy_q, ovfy_q, negy_q);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			now_q <= s_tdata[NOW_W-1:0];
			px_q <= s_tdata[NOW_W +: POS_W];
			py_q <= s_tdata[NOW_W+POS_W +: POS_W];
			vis_q <= s_tdata[NOW_W+2*POS_W];
			render_q <= {2'b00, s_tdata[NOW_W-1:0]} - {{(TIME_W-DLY_W){1'b0}}, delay_q};
		end
		if (cmd.rd_n) begin
			nx_q <= slot_before(ws_q);
		end else if (cmd.step_back) begin
			nx_q <= slot_before(nx_q);
		end
		if (cmd.ld_n || cmd.step_back) begin
			tn_q <= rd_time_q;
			xn_q <= rd_x_q;
			yn_q <= rd_y_q;
		end
		if (cmd.ld_n) begin
			upd_q <= status.render_le_n;
		end
		if (cmd.ld_p) begin
			tp_q <= rd_time_q;
			xp_q <= rd_x_q;
			yp_q <= rd_y_q;
		end
		if (cmd.lerp_setup) begin
			span_q <= span_d[TIME_W-1:0];
			an_q <= num_d[NUM_W-1] ? TIME_W'(-num_d) : num_d[TIME_W-1:0];
			adx_q <= dx_d[DIFF_W-1] ? -dx_d : dx_d;
			ady_q <= dy_d[DIFF_W-1] ? -dy_d : dy_d;
			negx_q <= dx_d[DIFF_W-1] ^ num_d[NUM_W-1];
			negy_q <= dy_d[DIFF_W-1] ^ num_d[NUM_W-1];
		end
		// The 25 x 42 product is built from two 25 x 21 partial products.
		if (cmd.mul_lo) begin
			prodx_q <= PROD_W'(adx_q * an_q[AN_LO_W-1:0]);
			prody_q <= PROD_W'(ady_q * an_q[AN_LO_W-1:0]);
		end else if (cmd.mul_hi) begin
			prodx_q <= prodx_q + (PROD_W'(adx_q * an_q[TIME_W-1:AN_LO_W]) << AN_LO_W);
			prody_q <= prody_q + (PROD_W'(ady_q * an_q[TIME_W-1:AN_LO_W]) << AN_LO_W);
		end else if (cmd.div_step) begin
			prodx_q <= prodx_q << 1;
			prody_q <= prody_q << 1;
		end
		// Restoring division; bits shifted out of the quotient mark overflow.
		if (cmd.mul_hi) begin
			remx_q <= '0;
			remy_q <= '0;
			qx_q <= '0;
			qy_q <= '0;
			ovfx_q <= 1'b0;
			ovfy_q <= 1'b0;
		end else if (cmd.div_step) begin
			remx_q <= gex ? TIME_W'(trialx - {1'b0, span_q}) : trialx[TIME_W-1:0];
			remy_q <= gey ? TIME_W'(trialy - {1'b0, span_q}) : trialy[TIME_W-1:0];
			qx_q <= {qx_q[Q_W-2:0], gex};
			qy_q <= {qy_q[Q_W-2:0], gey};
			ovfx_q <= ovfx_q | qx_q[Q_W-1];
			ovfy_q <= ovfy_q | qy_q[Q_W-1];
		end
		if (cmd.out_load) begin
			m_tdata <= {{(M_DATA_W-2*POS_W-1){1'b0}}, upd_q, shown_y_q, shown_x_q};
		end
	end

	a_span_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_step |-> (span_q != '0))
		else $error("divide with zero span");

	a_walk_off_ws: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.step_back |=> (nx_q != ws_q))
		else $error("walk reached the write slot");

	a_prev_then_cur: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.samp_prev_wr |=> cmd.samp_cur_wr)
		else $error("sample write pair broken");

endmodule

`default_nettype wire

### rtl/timestamped_position_interpolator_core.sv
// Timestamped position interpolator: ring of DEPTH (time, x, y) samples.
// Activate fills every slot; a sample writes one or two slots; operation 3 is
// ignored. A query ends after reading the newest entry when render time is after
// it, else walks back through older slots, and when it interpolates it runs a
// split multiply and a 67-step restoring divide; the result waits on m_tready.
// One item at a time. arst_n zeroes the slot pointer, display and delay
// register and sets the visibility flag; the ring itself is not reset.
`default_nettype none

module timestamped_position_interpolator_core #(
	parameter int DEPTH = 8
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           cfg_wr_en,
	input  wire logic [tspi_pkg::DLY_W-1:0]     cfg_wr_data,  // render_delay_ms
	input  wire logic                           s_tvalid,
	output logic                                s_tready,
	input  wire logic [tspi_pkg::S_DATA_W-1:0]  s_tdata,  // time_ms, pos_x, pos_y, visible
	input  wire logic [tspi_pkg::OP_W-1:0]      s_tuser,  // operation
	output logic                                m_tvalid,
	input  wire logic                           m_tready,
	output logic      [tspi_pkg::M_DATA_W-1:0]  m_tdata   // display_x, display_y, updated
);
	import tspi_pkg::*;

	tspi_cmd_t    cmd;
	tspi_status_t status;

	tspi_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.status   (status),
		.cmd      (cmd)
	);

	tspi_dp #(.DEPTH(DEPTH)) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.s_tdata     (s_tdata),
		.m_tdata     (m_tdata),
		.cmd         (cmd),
		.status      (status)
	);

endmodule

`default_nettype wire
